@@ design/sbq_pkg.sv @@
// shared types, constants and saturation helpers for the stereo biquad filter
`default_nettype none
package sbq_pkg;

  localparam int SAMPLE_WIDTH   = 16;
  localparam int COEF_WIDTH     = 24;
  localparam int COEF_FRAC_BITS = 20;
  localparam int STATE_WIDTH    = 32;
  localparam int STATE_FRAC     = STATE_WIDTH - SAMPLE_WIDTH - 4;

  // product of a coefficient and a state-width operand, accumulator with guard bits
  localparam int PROD_W = COEF_WIDTH + STATE_WIDTH;
  localparam int ACC_W  = PROD_W + 2;
  // accumulator after the coefficient shift, plus one bit for the delay add
  localparam int SUM_W  = ACC_W - COEF_FRAC_BITS + 1;
  localparam int SHR_W  = STATE_WIDTH - STATE_FRAC + 1;

  localparam int PADDR_W   = 5;
  localparam int REG_IDX_W = 3;

  localparam logic signed [ACC_W-1:0] ACC_HALF =
    ACC_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [STATE_WIDTH:0] RND_HALF =
    (STATE_WIDTH + 1)'(1) << (STATE_FRAC - 1);

  localparam logic signed [STATE_WIDTH-1:0] STATE_MAX = {1'b0, {(STATE_WIDTH-1){1'b1}}};
  localparam logic signed [STATE_WIDTH-1:0] STATE_MIN = {1'b1, {(STATE_WIDTH-1){1'b0}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  localparam logic signed [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(1) << COEF_FRAC_BITS;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ENABLE = 3'd0,
    REG_B0     = 3'd1,
    REG_B1     = 3'd2,
    REG_B2     = 3'd3,
    REG_A1     = 3'd4,
    REG_A2     = 3'd5
  } sbq_reg_e;

  typedef enum logic [2:0] {
    STEP_MUL_B0 = 3'd0,
    STEP_MUL_B1 = 3'd1,
    STEP_Y      = 3'd2,
    STEP_MUL_A1 = 3'd3,
    STEP_MUL_B2 = 3'd4,
    STEP_N1     = 3'd5,
    STEP_SUB_A2 = 3'd6,
    STEP_N2     = 3'd7
  } sbq_step_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } sbq_state_e;

  typedef struct packed {
    logic signed [COEF_WIDTH-1:0] b0;
    logic signed [COEF_WIDTH-1:0] b1;
    logic signed [COEF_WIDTH-1:0] b2;
    logic signed [COEF_WIDTH-1:0] a1;
    logic signed [COEF_WIDTH-1:0] a2;
  } sbq_coef_t;

  typedef struct packed {
    logic      run;
    sbq_step_e step;
  } sbq_ctrl_t;

  function automatic logic signed [STATE_WIDTH-1:0] sat_state(
    input logic signed [SUM_W-1:0] v
  );
    logic fits;
    fits = (&v[SUM_W-1:STATE_WIDTH-1]) || !(|v[SUM_W-1:STATE_WIDTH-1]);
    if (fits) begin
      return v[STATE_WIDTH-1:0];
    end else if (v[SUM_W-1]) begin
      return STATE_MIN;
    end else begin
      return STATE_MAX;
    end
  endfunction

  // round half up by the state fraction, then clip to the sample range
  function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
    input logic signed [STATE_WIDTH-1:0] y
  );
    logic signed [STATE_WIDTH:0] r;
    logic signed [SHR_W-1:0]     s;
    logic                        fits;
    r = {y[STATE_WIDTH-1], y} + RND_HALF;
    s = r[STATE_WIDTH:STATE_FRAC];
    fits = (&s[SHR_W-1:SAMPLE_WIDTH-1]) || !(|s[SHR_W-1:SAMPLE_WIDTH-1]);
    if (fits) begin
      return s[SAMPLE_WIDTH-1:0];
    end else if (s[SHR_W-1]) begin
      return SAMPLE_MIN;
    end else begin
      return SAMPLE_MAX;
    end
  endfunction

endpackage
`default_nettype wire

@@ design/sbq_cfg.sv @@
// configuration registers behind the apb port: enable flag and five coefficients
`default_nettype none
module sbq_cfg
  import sbq_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  output logic                    enable_o,
  output sbq_coef_t               coef_o
);

  logic      enable_q;
  sbq_coef_t coef_q;
  logic      wr_en;
  sbq_reg_e  idx;

  assign idx    = sbq_reg_e'(paddr[PADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= 1'b0;
      coef_q.b0 <= COEF_ONE;
      coef_q.b1 <= '0;
      coef_q.b2 <= '0;
      coef_q.a1 <= '0;
      coef_q.a2 <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_ENABLE: enable_q  <= pwdata[0];
        REG_B0:     coef_q.b0 <= pwdata[COEF_WIDTH-1:0];
        REG_B1:     coef_q.b1 <= pwdata[COEF_WIDTH-1:0];
        REG_B2:     coef_q.b2 <= pwdata[COEF_WIDTH-1:0];
        REG_A1:     coef_q.a1 <= pwdata[COEF_WIDTH-1:0];
        REG_A2:     coef_q.a2 <= pwdata[COEF_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ENABLE: prdata = {31'd0, enable_q};
      REG_B0:     prdata = {{(32-COEF_WIDTH){1'b0}}, coef_q.b0};
      REG_B1:     prdata = {{(32-COEF_WIDTH){1'b0}}, coef_q.b1};
      REG_B2:     prdata = {{(32-COEF_WIDTH){1'b0}}, coef_q.b2};
      REG_A1:     prdata = {{(32-COEF_WIDTH){1'b0}}, coef_q.a1};
      REG_A2:     prdata = {{(32-COEF_WIDTH){1'b0}}, coef_q.a2};
      default:    prdata = 32'd0;
    endcase
  end

  assign enable_o = enable_q;
  assign coef_o   = coef_q;

endmodule
`default_nettype wire

@@ design/sbq_lane.sv @@
// one channel of the biquad: shared multiplier, accumulator and two delay registers
`default_nettype none
module sbq_lane
  import sbq_pkg::*;
(
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire sbq_ctrl_t                      ctrl_i,
  input  wire sbq_coef_t                      coef_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] x_i,
  output logic signed [SAMPLE_WIDTH-1:0]      sample_o
);

  logic signed [PROD_W-1:0]       prod_q;
  logic signed [ACC_W-1:0]        acc_q;
  logic signed [STATE_WIDTH-1:0]  y_q;
  logic signed [STATE_WIDTH-1:0]  d1_q;
  logic signed [STATE_WIDTH-1:0]  d2_q;
  logic signed [SAMPLE_WIDTH-1:0] sample_q;

  logic signed [COEF_WIDTH-1:0]   mul_coef;
  logic signed [STATE_WIDTH-1:0]  mul_opnd;
  logic signed [STATE_WIDTH-1:0]  x_ext;
  logic signed [ACC_W-1:0]        prod_ext;
  logic signed [ACC_W-1:0]        acc_start;
  logic signed [SUM_W-1:0]        acc_shr;

  assign x_ext = {{(STATE_WIDTH-SAMPLE_WIDTH){x_i[SAMPLE_WIDTH-1]}}, x_i};

  always_comb begin
    mul_opnd = x_ext;
    case (ctrl_i.step)
      STEP_MUL_B0: mul_coef = coef_i.b0;
      STEP_MUL_B1: mul_coef = coef_i.b1;
      STEP_MUL_A1: begin
        mul_coef = coef_i.a1;
        mul_opnd = y_q;
      end
      STEP_MUL_B2: mul_coef = coef_i.b2;
      STEP_N1: begin
        mul_coef = coef_i.a2;
        mul_opnd = y_q;
      end
      default:     mul_coef = coef_i.b0;
    endcase
  end

  // x terms are scaled up by the state fraction before accumulation
  assign prod_ext  = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
  assign acc_start = (prod_ext <<< STATE_FRAC) + ACC_HALF;
  assign acc_shr   = {acc_q[ACC_W-1], acc_q[ACC_W-1:COEF_FRAC_BITS]};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.run) begin
      prod_q <= mul_coef * mul_opnd;
      case (ctrl_i.step)
        STEP_MUL_B1: acc_q <= acc_start;
        STEP_Y: begin
          y_q   <= sat_state(acc_shr + SUM_W'(d1_q));
          acc_q <= acc_start;
        end
        STEP_MUL_B2: acc_q <= acc_q - prod_ext;
        STEP_N1:     acc_q <= acc_start;
        STEP_SUB_A2: acc_q <= acc_q - prod_ext;
        STEP_N2:     sample_q <= sat_sample(y_q);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_q <= '0;
      d2_q <= '0;
    end else if (ctrl_i.run) begin
      case (ctrl_i.step)
        STEP_N1: d1_q <= sat_state(acc_shr + SUM_W'(d2_q));
        STEP_N2: d2_q <= sat_state(acc_shr);
        default: ;
      endcase
    end
  end

  assign sample_o = sample_q;

endmodule
`default_nettype wire

@@ design/stereo_biquad_lowpass_unit.sv @@
// top level: frame sequencer, config registers, two biquad lanes, output merge and register
//
//  channel  | dir | handshake                  | payload
//  ---------+-----+----------------------------+-------------------------
//  in       | in  | in_valid_i / in_stall_o    | left_in_i, right_in_i
//  out      | out | out_valid_o / out_stall_i  | left_out_o, right_out_o
//  config   | in  | apb psel/penable/pready    | paddr, pwdata, prdata
//
// a filtered frame runs through the eight lane steps and is then merged into the
// output register; with the filter disabled the input samples go straight to the
// merge and the state is held. no new frame is taken until the last is merged.
// rst_ni clears the delay registers and the handshake state; the configuration
// resets to disabled, b0 one, others zero. a frame is taken while the previous
// result waits in the output register; a finished frame waits until that is free.
`default_nettype none
module stereo_biquad_lowpass_unit
  import sbq_pkg::*;
(
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic signed [SAMPLE_WIDTH-1:0] left_in_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] right_in_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0]      left_out_o,
  output logic signed [SAMPLE_WIDTH-1:0]      right_out_o,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [PADDR_W-1:0]             paddr,
  input  wire logic [31:0]                    pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  sbq_state_e state_q, state_d;
  sbq_step_e  step_q, step_d;
  logic       bypass_q;
  logic       out_valid_q, out_valid_d;
  logic       in_acc, out_free, load_out;

  logic signed [SAMPLE_WIDTH-1:0] x_l_q, x_r_q;
  logic signed [SAMPLE_WIDTH-1:0] out_l_q, out_r_q;
  logic signed [SAMPLE_WIDTH-1:0] lane_l, lane_r;

  logic      enable;
  sbq_coef_t coef;
  sbq_ctrl_t ctrl;

  sbq_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .enable_o (enable),
    .coef_o   (coef)
  );

  sbq_lane u_lane_l (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .coef_i   (coef),
    .x_i      (x_l_q),
    .sample_o (lane_l)
  );

  sbq_lane u_lane_r (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .coef_i   (coef),
    .x_i      (x_r_q),
    .sample_o (lane_r)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign ctrl.run   = (state_q == ST_RUN);
  assign ctrl.step  = step_q;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    load_out    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        step_d = STEP_MUL_B0;
        if (in_valid_i) begin
          state_d = enable ? ST_RUN : ST_DONE;
        end
      end
      ST_RUN: begin
        step_d = sbq_step_e'(step_q + 3'd1);
        if (step_q == STEP_N2) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= STEP_MUL_B0;
      bypass_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        bypass_q <= !enable;
      end
    end
  end

  // merge: pass-through samples or the two lane results
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_l_q <= left_in_i;
      x_r_q <= right_in_i;
    end
    if (load_out) begin
      out_l_q <= bypass_q ? x_l_q : lane_l;
      out_r_q <= bypass_q ? x_r_q : lane_r;
    end
  end

  assign out_valid_o = out_valid_q;
  assign left_out_o  = out_l_q;
  assign right_out_o = out_r_q;

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q != ST_IDLE))
    else $error("accepted transaction did not start the sequencer");

  a_bypass_skips_lanes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !enable) |=> (state_q == ST_DONE) && bypass_q)
    else $error("pass-through transaction entered the lanes");

  a_run_ends_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && step_q == STEP_N2) |=> (state_q == ST_DONE))
    else $error("lane sequence did not finish after the last step");

  a_done_loads_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> out_valid_q && (state_q == ST_IDLE))
    else $error("finished frame not moved to the output register");
`endif

endmodule
`default_nettype wire
